[sv/rpp_pkg.sv]
// Package with the shared types, constants and arctangent table of the point rotation block.
`timescale 1ns / 1ps
`default_nettype none
package rpp_pkg;

  localparam int unsigned CordicStagesDefault = 16;

  localparam int unsigned CoordW = 32;
  localparam int unsigned AngleW = 16;
  localparam int unsigned DiffW  = CoordW + 1;
  localparam int unsigned CordW  = 34;
  localparam int unsigned PhaseW = 33;
  localparam int unsigned TrigW  = 32;
  localparam int unsigned ProdW  = DiffW + TrigW;
  localparam int unsigned SumW   = ProdW + 1;
  localparam int unsigned RndW   = SumW - 30;
  localparam int unsigned OutW   = RndW + 1;

  localparam logic signed [CordW-1:0] GainQ30   = 34'sd652032874;
  localparam logic signed [CordW-1:0] Q30One    = 34'sd1073741824;
  localparam logic signed [CordW-1:0] Q30NegOne = -34'sd1073741824;
  localparam logic signed [SumW-1:0]  RoundHalf = 66'sd536870912;

  typedef struct packed {
    logic signed [CordW-1:0]  x;
    logic signed [CordW-1:0]  y;
    logic signed [PhaseW-1:0] z;
    logic                     neg;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } cord_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[sv/rpp_cordic_stage.sv]
// One registered rotation-mode CORDIC iteration with its own valid bit and backpressure.
`timescale 1ns / 1ps
`default_nettype none
module rpp_cordic_stage #(
  parameter int unsigned Idx = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               ready_o,
  input  wire rpp_pkg::cord_t data_i,
  output logic               valid_o,
  input  wire logic          ready_i,
  output rpp_pkg::cord_t     data_o
);

  logic                                  vld_q;
  rpp_pkg::cord_t                        data_q;
  rpp_pkg::cord_t                        data_d;
  logic signed [rpp_pkg::CordW-1:0]      x_in;
  logic signed [rpp_pkg::CordW-1:0]      y_in;
  logic signed [rpp_pkg::CordW-1:0]      xs;
  logic signed [rpp_pkg::CordW-1:0]      ys;
  logic signed [rpp_pkg::PhaseW-1:0]     z_in;
  logic signed [rpp_pkg::PhaseW-1:0]     step;

  assign x_in = data_i.x;
  assign y_in = data_i.y;
  assign z_in = data_i.z;
  assign xs   = x_in >>> Idx;
  assign ys   = y_in >>> Idx;
  assign step = signed'({1'b0, rpp_pkg::atan_lut(5'(Idx))});

  always_comb begin
    data_d = data_i;
    if (!z_in[rpp_pkg::PhaseW-1]) begin
      data_d.x = x_in - ys;
      data_d.y = y_in + xs;
      data_d.z = z_in - step;
    end else begin
      data_d.x = x_in + ys;
      data_d.y = y_in - xs;
      data_d.z = z_in + step;
    end
  end

  assign ready_o = !vld_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = vld_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

[sv/rotate_point_about_pivot_2d.sv]
// Top level of the pipelined rotation of a Q16.16 point about a pivot by a binary angle.
//
// Channel  | Direction | tdata fields (lowest bit up)                        | tuser
// s_axis   | in        | point_x, point_y, pivot_x, pivot_y, turn_angle      | none
// m_axis   | out       | rotated_x, rotated_y                                | overflow
//
// One request is taken per cycle unless backpressure from m_axis stalls the pipeline.
// The pipeline holds an input stage, the unrolled CORDIC chain with one iteration per stage,
// and stages for sign and clamp, the four multipliers, rounding and saturation.
// Every stage has its own valid bit, so bubbles close up under backpressure.
// Reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module rotate_point_about_pivot_2d #(
  parameter int unsigned CORDIC_STAGES = rpp_pkg::CordicStagesDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // point_x, point_y, pivot_x, pivot_y, turn_angle
  input  wire logic [143:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // rotated_x, rotated_y
  output logic [63:0]       m_axis_tdata,
  // overflow
  output logic              m_axis_tuser
);

  localparam int unsigned CW = rpp_pkg::CoordW;

  // Input stage: fold the angle and form the differences.
  logic signed [CW-1:0]               px;
  logic signed [CW-1:0]               py;
  logic signed [CW-1:0]               cxi;
  logic signed [CW-1:0]               cyi;
  logic [rpp_pkg::AngleW-1:0]         ang;
  logic [rpp_pkg::AngleW-1:0]         ang_f;
  logic                               fold;
  logic                               vld_a_q;
  logic                               rdy_a;
  rpp_pkg::cord_t                     cord_a_q;
  rpp_pkg::cord_t                     cord_a_d;

  assign px    = s_axis_tdata[31:0];
  assign py    = s_axis_tdata[63:32];
  assign cxi   = s_axis_tdata[95:64];
  assign cyi   = s_axis_tdata[127:96];
  assign ang   = s_axis_tdata[143:128];
  assign fold  = ang[15] ^ ang[14];
  assign ang_f = fold ? (ang ^ 16'h8000) : ang;

  always_comb begin
    cord_a_d     = '0;
    cord_a_d.x   = rpp_pkg::GainQ30;
    cord_a_d.y   = '0;
    cord_a_d.z   = signed'({ang_f[15], ang_f, 16'h0000});
    cord_a_d.neg = fold;
    cord_a_d.dx  = 33'(px) - 33'(cxi);
    cord_a_d.dy  = 33'(py) - 33'(cyi);
    cord_a_d.cx  = cxi;
    cord_a_d.cy  = cyi;
  end

  logic           chain_vld [0:CORDIC_STAGES];
  logic           chain_rdy [0:CORDIC_STAGES];
  rpp_pkg::cord_t chain_dat [0:CORDIC_STAGES];

  assign rdy_a         = !vld_a_q || chain_rdy[0];
  assign s_axis_tready = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else if (rdy_a) begin
      vld_a_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && s_axis_tvalid) begin
      cord_a_q <= cord_a_d;
    end
  end

  assign chain_vld[0] = vld_a_q;
  assign chain_dat[0] = cord_a_q;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    rpp_cordic_stage #(
      .Idx(g)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(chain_vld[g]),
      .ready_o(chain_rdy[g]),
      .data_i (chain_dat[g]),
      .valid_o(chain_vld[g+1]),
      .ready_i(chain_rdy[g+1]),
      .data_o (chain_dat[g+1])
    );
  end

  // Sign and clamp stage.
  logic                                vld_b_q;
  logic                                rdy_b;
  logic                                rdy_c;
  logic signed [rpp_pkg::CordW-1:0]    xn;
  logic signed [rpp_pkg::CordW-1:0]    yn;
  logic signed [rpp_pkg::CordW-1:0]    xe;
  logic signed [rpp_pkg::CordW-1:0]    ye;
  logic signed [rpp_pkg::TrigW-1:0]    cos_d;
  logic signed [rpp_pkg::TrigW-1:0]    sin_d;
  logic signed [rpp_pkg::TrigW-1:0]    cos_q;
  logic signed [rpp_pkg::TrigW-1:0]    sin_q;
  logic signed [rpp_pkg::DiffW-1:0]    dx_b_q;
  logic signed [rpp_pkg::DiffW-1:0]    dy_b_q;
  logic signed [CW-1:0]                cx_b_q;
  logic signed [CW-1:0]                cy_b_q;

  assign xe = chain_dat[CORDIC_STAGES].x;
  assign ye = chain_dat[CORDIC_STAGES].y;
  assign xn = chain_dat[CORDIC_STAGES].neg ? -xe : xe;
  assign yn = chain_dat[CORDIC_STAGES].neg ? -ye : ye;

  always_comb begin
    if (xn > rpp_pkg::Q30One) begin
      cos_d = 32'(rpp_pkg::Q30One);
    end else if (xn < rpp_pkg::Q30NegOne) begin
      cos_d = 32'(rpp_pkg::Q30NegOne);
    end else begin
      cos_d = xn[31:0];
    end
    if (yn > rpp_pkg::Q30One) begin
      sin_d = 32'(rpp_pkg::Q30One);
    end else if (yn < rpp_pkg::Q30NegOne) begin
      sin_d = 32'(rpp_pkg::Q30NegOne);
    end else begin
      sin_d = yn[31:0];
    end
  end

  assign rdy_b                    = !vld_b_q || rdy_c;
  assign chain_rdy[CORDIC_STAGES] = rdy_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else if (rdy_b) begin
      vld_b_q <= chain_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_b && chain_vld[CORDIC_STAGES]) begin
      cos_q  <= cos_d;
      sin_q  <= sin_d;
      dx_b_q <= chain_dat[CORDIC_STAGES].dx;
      dy_b_q <= chain_dat[CORDIC_STAGES].dy;
      cx_b_q <= chain_dat[CORDIC_STAGES].cx;
      cy_b_q <= chain_dat[CORDIC_STAGES].cy;
    end
  end

  // Multiplier stage.
  logic                                vld_c_q;
  logic                                rdy_r;
  logic signed [rpp_pkg::ProdW-1:0]    dxc_d;
  logic signed [rpp_pkg::ProdW-1:0]    dxs_d;
  logic signed [rpp_pkg::ProdW-1:0]    dyc_d;
  logic signed [rpp_pkg::ProdW-1:0]    dys_d;
  logic signed [rpp_pkg::ProdW-1:0]    dxc_q;
  logic signed [rpp_pkg::ProdW-1:0]    dxs_q;
  logic signed [rpp_pkg::ProdW-1:0]    dyc_q;
  logic signed [rpp_pkg::ProdW-1:0]    dys_q;
  logic signed [CW-1:0]                cx_c_q;
  logic signed [CW-1:0]                cy_c_q;

  assign dxc_d = rpp_pkg::ProdW'(dx_b_q) * rpp_pkg::ProdW'(cos_q);
  assign dxs_d = rpp_pkg::ProdW'(dx_b_q) * rpp_pkg::ProdW'(sin_q);
  assign dyc_d = rpp_pkg::ProdW'(dy_b_q) * rpp_pkg::ProdW'(cos_q);
  assign dys_d = rpp_pkg::ProdW'(dy_b_q) * rpp_pkg::ProdW'(sin_q);

  assign rdy_c = !vld_c_q || rdy_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else if (rdy_c) begin
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && vld_b_q) begin
      dxc_q  <= dxc_d;
      dxs_q  <= dxs_d;
      dyc_q  <= dyc_d;
      dys_q  <= dys_d;
      cx_c_q <= cx_b_q;
      cy_c_q <= cy_b_q;
    end
  end

  // Combine and round stage.
  logic                                vld_r_q;
  logic                                rdy_o;
  logic signed [rpp_pkg::SumW-1:0]     sum_x;
  logic signed [rpp_pkg::SumW-1:0]     sum_y;
  logic signed [rpp_pkg::RndW-1:0]     rnd_x_q;
  logic signed [rpp_pkg::RndW-1:0]     rnd_y_q;
  logic signed [CW-1:0]                cx_r_q;
  logic signed [CW-1:0]                cy_r_q;

  assign sum_x = rpp_pkg::SumW'(dxc_q) - rpp_pkg::SumW'(dys_q) + rpp_pkg::RoundHalf;
  assign sum_y = rpp_pkg::SumW'(dyc_q) + rpp_pkg::SumW'(dxs_q) + rpp_pkg::RoundHalf;

  assign rdy_r = !vld_r_q || rdy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_r_q <= 1'b0;
    end else if (rdy_r) begin
      vld_r_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_r && vld_c_q) begin
      rnd_x_q <= sum_x[rpp_pkg::SumW-1:30];
      rnd_y_q <= sum_y[rpp_pkg::SumW-1:30];
      cx_r_q  <= cx_c_q;
      cy_r_q  <= cy_c_q;
    end
  end

  // Pivot add, saturation and output register.
  logic                                vld_o_q;
  logic signed [rpp_pkg::OutW-1:0]     fin_x;
  logic signed [rpp_pkg::OutW-1:0]     fin_y;
  logic                                ovf_x;
  logic                                ovf_y;
  logic [CW-1:0]                       sat_x;
  logic [CW-1:0]                       sat_y;
  logic [CW-1:0]                       rx_q;
  logic [CW-1:0]                       ry_q;
  logic                                ovf_q;

  assign fin_x = rpp_pkg::OutW'(rnd_x_q) + rpp_pkg::OutW'(cx_r_q);
  assign fin_y = rpp_pkg::OutW'(rnd_y_q) + rpp_pkg::OutW'(cy_r_q);
  assign ovf_x = !((&fin_x[rpp_pkg::OutW-1:CW-1]) || !(|fin_x[rpp_pkg::OutW-1:CW-1]));
  assign ovf_y = !((&fin_y[rpp_pkg::OutW-1:CW-1]) || !(|fin_y[rpp_pkg::OutW-1:CW-1]));
  assign sat_x = ovf_x ? (fin_x[rpp_pkg::OutW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                       : fin_x[CW-1:0];
  assign sat_y = ovf_y ? (fin_y[rpp_pkg::OutW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                       : fin_y[CW-1:0];

  assign rdy_o = !vld_o_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o_q <= 1'b0;
    end else if (rdy_o) begin
      vld_o_q <= vld_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_r_q) begin
      rx_q  <= sat_x;
      ry_q  <= sat_y;
      ovf_q <= ovf_x || ovf_y;
    end
  end

  assign m_axis_tvalid = vld_o_q;
  assign m_axis_tdata  = {ry_q, rx_q};
  assign m_axis_tuser  = ovf_q;

  // The folded phase entering the CORDIC stays within a quarter turn either way.
  a_phase_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a_q |-> (cord_a_q.z <= 33'sd1073741824 && cord_a_q.z >= -33'sd1073741824))
    else $error("CORDIC start phase outside a quarter turn");

  // Sine and cosine never leave the clamped unit range.
  a_trig_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_b_q |-> (cos_q <= 32'sd1073741824 && cos_q >= -32'sd1073741824 &&
                 sin_q <= 32'sd1073741824 && sin_q >= -32'sd1073741824))
    else $error("Sine or cosine outside the unit range");

  // A flagged result carries a saturated coordinate.
  a_ovf_saturated : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000 ||
       m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000))
    else $error("Overflow flagged without a saturated coordinate");

  // A rounded value that reached the output stage moves on when the output is free.
  a_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_r_q && (!vld_o_q || m_axis_tready)) |=> vld_o_q)
    else $error("Result lost between rounding and output");

endmodule
`default_nettype wire
